@@ rtl/cdo_pkg.sv @@
// Shared types, codes and calendar helpers for the calendar day offset block.
// Depends on nothing; cdo_front, cdo_back and calendar_day_offset import it.
package cdo_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   // operation selector codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   // month numbers used by the month length decoder
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // month lengths
   localparam logic [4:0] LEN_LONG      = 5'd31;
   localparam logic [4:0] LEN_SHORT     = 5'd30;
   localparam logic [4:0] LEN_FEB_LEAP  = 5'd29;
   localparam logic [4:0] LEN_FEB_PLAIN = 5'd28;

   // year position within the 400-year Gregorian cycle; 400 splits as 25 * 16
   localparam int         MOD_WIDTH      = 9;
   localparam int         CYCLE_LOW_BITS = 4;
   localparam int         CYCLE_ODD      = 25;
   localparam int         CYCLE_ODD_BITS = 5;
   localparam logic [8:0] CYCLE_LAST     = 9'd399;
   localparam logic [8:0] CENTURY_1      = 9'd100;
   localparam logic [8:0] CENTURY_2      = 9'd200;
   localparam logic [8:0] CENTURY_3      = 9'd300;

   // queue entry bits that do not depend on the width parameters:
   // op, status, month, day, year-in-cycle
   localparam int ENTRY_FIXED = 1 + 2 + 4 + 5 + MOD_WIDTH;

   // front end sequencer states
   typedef enum logic [1:0] {
      F_IDLE,
      F_REDUCE,
      F_PUSH
   } front_state_type;

   // back end sequencer states
   typedef enum logic {
      B_IDLE,
      B_RUN
   } back_state_type;

   // leap year from the year's position in the 400-year cycle
   function automatic logic is_leap(input logic [MOD_WIDTH-1:0] ymod);
      is_leap = (ymod[1:0] == 2'b00) && (ymod != CENTURY_1) &&
                (ymod != CENTURY_2) && (ymod != CENTURY_3);
   endfunction

   // days in a month; codes outside 1..12 read as a long month
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB_PLAIN;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
         default: len = LEN_LONG;
      endcase
      month_len = len;
   endfunction

endpackage

@@ rtl/cdo_req_if.sv @@
// Request channel of the calendar day offset block: valid/ready plus payload.
// Depends on nothing.
interface cdo_req_if #(
   parameter int DAYS_WIDTH = 16,
   parameter int YEAR_WIDTH = 14
);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic                  date_present;
   logic [3:0]            start_month;
   logic [4:0]            start_day;
   logic [YEAR_WIDTH-1:0] start_year;
   logic [DAYS_WIDTH-1:0] day_count;

   modport source (
      output valid, op, date_present, start_month, start_day, start_year, day_count,
      input  ready
   );

   modport sink (
      input  valid, op, date_present, start_month, start_day, start_year, day_count,
      output ready
   );
endinterface

@@ rtl/cdo_rsp_if.sv @@
// Response channel of the calendar day offset block: valid/ready plus payload.
// Depends on nothing.
interface cdo_rsp_if #(
   parameter int YEAR_WIDTH = 14
);
   logic                  valid;
   logic                  ready;
   logic [3:0]            result_month;
   logic [4:0]            result_day;
   logic [YEAR_WIDTH-1:0] result_year;
   logic [1:0]            status;

   modport source (
      output valid, result_month, result_day, result_year, status,
      input  ready
   );

   modport sink (
      input  valid, result_month, result_day, result_year, status,
      output ready
   );
endinterface

@@ rtl/cdo_front.sv @@
// Front end: accepts a request, reduces the year modulo 400 by a reciprocal multiply,
// checks the start date and pushes a classified entry. Uses cdo_pkg, cdo_req_if.
module cdo_front #(
   parameter int DAYS_WIDTH = 16,
   parameter int YEAR_WIDTH = 14
) (
   input  logic clock,
   input  logic reset,
   cdo_req_if.sink req_ch,
   output logic push_valid,
   input  logic push_ready,
   output logic [cdo_pkg::ENTRY_FIXED+YEAR_WIDTH+DAYS_WIDTH-1:0] push_data
);
   import cdo_pkg::*;

   localparam int HI_WIDTH    = YEAR_WIDTH - CYCLE_LOW_BITS;
   localparam int RECIP_SHIFT = HI_WIDTH + CYCLE_ODD_BITS;
   localparam int RECIP_WIDTH = RECIP_SHIFT - CYCLE_LOW_BITS;
   localparam int PROD_WIDTH  = HI_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] RECIP =
      RECIP_WIDTH'(((64'd1 << RECIP_SHIFT) + 64'(CYCLE_ODD - 1)) / 64'(CYCLE_ODD));

   typedef struct packed {
      logic                  op;
      status_type            status;
      logic [3:0]            month;
      logic [4:0]            day;
      logic [YEAR_WIDTH-1:0] year;
      logic [MOD_WIDTH-1:0]  ymod;
      logic [DAYS_WIDTH-1:0] count;
   } entry_type;

   front_state_type         state_ff, state_in;
   logic                    op_ff, op_in;
   logic                    present_ff, present_in;
   logic [3:0]              month_ff, month_in;
   logic [4:0]              day_ff, day_in;
   logic [YEAR_WIDTH-1:0]   year_ff, year_in;
   logic [DAYS_WIDTH-1:0]   count_ff, count_in;
   logic [MOD_WIDTH-1:0]    ymod_ff, ymod_in;
   logic [HI_WIDTH-1:0]     year_hi;
   logic [PROD_WIDTH-1:0]   recip_prod;
   logic [PROD_WIDTH-1:0]   year_quot;
   logic [CYCLE_ODD_BITS-1:0] year_rem;
   logic [MOD_WIDTH-1:0]    ymod_calc;
   logic                    date_ok;
   entry_type               entry;

   // year modulo 400: keep the low four bits, take the rest modulo 25
   always_comb begin
      year_hi    = year_ff[YEAR_WIDTH-1:CYCLE_LOW_BITS];
      recip_prod = PROD_WIDTH'(year_hi) * PROD_WIDTH'(RECIP);
      year_quot  = recip_prod >> RECIP_SHIFT;
      year_rem   = CYCLE_ODD_BITS'(PROD_WIDTH'(year_hi) - year_quot * PROD_WIDTH'(CYCLE_ODD));
      ymod_calc  = {year_rem, year_ff[CYCLE_LOW_BITS-1:0]};
   end

   // check the start date against its own month and year
   always_comb begin
      date_ok = present_ff && (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
                (year_ff != '0) && (day_ff != 5'd0) &&
                (day_ff <= month_len(month_ff, is_leap(ymod_ff)));
   end

   // build the queue entry
   always_comb begin
      entry.op     = op_ff;
      entry.status = date_ok ? STATUS_OK : STATUS_BAD_DATE;
      entry.month  = month_ff;
      entry.day    = day_ff;
      entry.year   = year_ff;
      entry.ymod   = ymod_ff;
      entry.count  = count_ff;
   end

   assign push_data = entry;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      present_ff <= present_in;
      month_ff   <= month_in;
      day_ff     <= day_in;
      year_ff    <= year_in;
      count_ff   <= count_in;
      ymod_ff    <= ymod_in;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      present_in   = present_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      year_in      = year_ff;
      count_in     = count_ff;
      ymod_in      = ymod_ff;
      req_ch.ready = 1'b0;
      push_valid   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               op_in      = req_ch.op;
               present_in = req_ch.date_present;
               month_in   = req_ch.start_month;
               day_in     = req_ch.start_day;
               year_in    = req_ch.start_year;
               count_in   = req_ch.day_count;
               state_in   = F_REDUCE;
            end
         end
         F_REDUCE: begin
            ymod_in  = ymod_calc;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

endmodule

@@ rtl/cdo_queue.sv @@
// Two-entry queue between the front and back ends of the date offset block.
// Depends on nothing; the entry width comes in as a parameter.
module cdo_queue #(
   parameter int WIDTH = 51
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/cdo_back.sv @@
// Back end: walks the date one month per cycle and holds the response register.
// Uses cdo_pkg and cdo_rsp_if.
module cdo_back #(
   parameter int DAYS_WIDTH = 16,
   parameter int YEAR_WIDTH = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [cdo_pkg::ENTRY_FIXED+YEAR_WIDTH+DAYS_WIDTH-1:0] pop_data,
   cdo_rsp_if.source rsp_ch
);
   import cdo_pkg::*;

   localparam int                    DW       = DAYS_WIDTH + 2;
   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};
   localparam logic [YEAR_WIDTH-1:0] YEAR_MIN = YEAR_WIDTH'(1);

   typedef struct packed {
      logic                  op;
      status_type            status;
      logic [3:0]            month;
      logic [4:0]            day;
      logic [YEAR_WIDTH-1:0] year;
      logic [MOD_WIDTH-1:0]  ymod;
      logic [DAYS_WIDTH-1:0] count;
   } entry_type;

   back_state_type          state_ff, state_in;
   logic                    op_ff, op_in;
   status_type              status_ff, status_in;
   logic [3:0]              month_ff, month_in;
   logic signed [DW-1:0]    day_ff, day_in;
   logic [YEAR_WIDTH-1:0]   year_ff, year_in;
   logic [MOD_WIDTH-1:0]    ymod_ff, ymod_in;

   logic                    out_valid_ff, out_valid_in;
   logic [3:0]              out_month_ff, out_month_in;
   logic [4:0]              out_day_ff, out_day_in;
   logic [YEAR_WIDTH-1:0]   out_year_ff, out_year_in;
   status_type              out_status_ff, out_status_in;

   entry_type               entry;
   logic signed [DW-1:0]    start_day_ext;
   logic signed [DW-1:0]    count_ext;
   logic signed [DW-1:0]    len_cur_ext;
   logic signed [DW-1:0]    len_prev_ext;
   logic [4:0]              len_cur;
   logic [4:0]              len_prev;
   logic                    year_wrap_up;
   logic                    year_wrap_down;
   logic [MOD_WIDTH-1:0]    ymod_up;
   logic [MOD_WIDTH-1:0]    ymod_down;
   logic [3:0]              month_prev;
   logic [YEAR_WIDTH-1:0]   year_prev;
   logic [MOD_WIDTH-1:0]    ymod_prev;
   logic                    finished;
   logic                    slot_free;

   assign entry         = pop_data;
   assign start_day_ext = DW'(signed'({1'b0, entry.day}));
   assign count_ext     = DW'(signed'({1'b0, entry.count}));

   // month lengths and neighbor months for one step
   always_comb begin
      len_cur        = month_len(month_ff, is_leap(ymod_ff));
      year_wrap_up   = (month_ff == MONTH_DEC);
      year_wrap_down = (month_ff == MONTH_JAN);
      ymod_up        = (ymod_ff == CYCLE_LAST) ? '0 : ymod_ff + 1'b1;
      ymod_down      = (ymod_ff == '0) ? CYCLE_LAST : ymod_ff - 1'b1;
      month_prev     = year_wrap_down ? MONTH_DEC : month_ff - 4'd1;
      year_prev      = year_wrap_down ? year_ff - 1'b1 : year_ff;
      ymod_prev      = year_wrap_down ? ymod_down : ymod_ff;
      len_prev       = month_len(month_prev, is_leap(ymod_prev));
      len_cur_ext    = DW'(signed'({1'b0, len_cur}));
      len_prev_ext   = DW'(signed'({1'b0, len_prev}));
      if (status_ff != STATUS_OK) begin
         finished = 1'b1;
      end else if (op_ff == OP_SUB) begin
         finished = (day_ff >= DW'(signed'(2'sb01)));
      end else begin
         finished = (day_ff <= len_cur_ext);
      end
   end

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = (state_ff == B_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      month_ff      <= month_in;
      day_ff        <= day_in;
      year_ff       <= year_in;
      ymod_ff       <= ymod_in;
      out_month_ff  <= out_month_in;
      out_day_ff    <= out_day_in;
      out_year_ff   <= out_year_in;
      out_status_ff <= out_status_in;
   end

   // load, step one month, or retire into the response register
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      year_in       = year_ff;
      ymod_in       = ymod_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_month_in  = out_month_ff;
      out_day_in    = out_day_ff;
      out_year_in   = out_year_ff;
      out_status_in = out_status_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               op_in     = entry.op;
               status_in = entry.status;
               month_in  = entry.month;
               year_in   = entry.year;
               ymod_in   = entry.ymod;
               day_in    = (entry.op == OP_SUB) ? start_day_ext - count_ext
                                                : start_day_ext + count_ext;
               state_in  = B_RUN;
            end
         end
         B_RUN: begin
            if (finished) begin
               if (slot_free) begin
                  out_valid_in  = 1'b1;
                  out_status_in = status_ff;
                  if (status_ff == STATUS_OK) begin
                     out_month_in = month_ff;
                     out_day_in   = day_ff[4:0];
                     out_year_in  = year_ff;
                  end else begin
                     out_month_in = '0;
                     out_day_in   = '0;
                     out_year_in  = '0;
                  end
                  state_in = B_IDLE;
               end
            end else if (op_ff == OP_SUB) begin
               // borrow the previous month
               if (year_wrap_down && (year_ff == YEAR_MIN)) begin
                  status_in = STATUS_RANGE;
               end else begin
                  month_in = month_prev;
                  year_in  = year_prev;
                  ymod_in  = ymod_prev;
                  day_in   = day_ff + len_prev_ext;
               end
            end else begin
               // carry into the next month
               day_in = day_ff - len_cur_ext;
               if (year_wrap_up) begin
                  month_in = MONTH_JAN;
                  year_in  = year_ff + 1'b1;
                  ymod_in  = ymod_up;
                  if (year_ff == YEAR_MAX) begin
                     status_in = STATUS_RANGE;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_month = out_month_ff;
   assign rsp_ch.result_day   = out_day_ff;
   assign rsp_ch.result_year  = out_year_ff;
   assign rsp_ch.status       = out_status_ff;

endmodule

@@ rtl/calendar_day_offset.sv @@
// Top level of the calendar day offset block: front end, queue, back end.
// Uses cdo_pkg, cdo_req_if, cdo_rsp_if, cdo_front, cdo_queue, cdo_back.
//
//   channel   direction   handshake         payload
//   req_ch    in          valid / ready     op, date_present, start_month/day/year, day_count
//   rsp_ch    out         valid / ready     result_month/day/year, status
//
// Front end steps through accept, year modulo 400 by a reciprocal multiply, then the
// date check and queue push, which waits for queue room, before taking a new request.
// Back end crosses one month boundary per cycle in the month walk loop, then retires
// when the response register is free; a full count of 65535 days crosses about 2150.
// Reset clears the sequencers, queue pointers and occupancy, and response valid; nothing else.
// A two-entry queue and the response register let either side stall alone.
module calendar_day_offset #(
   parameter int DAYS_WIDTH = 16,
   parameter int YEAR_WIDTH = 14
) (
   input logic clock,
   input logic reset,
   cdo_req_if.sink   req_ch,
   cdo_rsp_if.source rsp_ch
);
   import cdo_pkg::*;

   localparam int ENTRY_WIDTH = ENTRY_FIXED + YEAR_WIDTH + DAYS_WIDTH;

   logic                   push_valid;
   logic                   push_ready;
   logic [ENTRY_WIDTH-1:0] push_data;
   logic                   pop_valid;
   logic                   pop_ready;
   logic [ENTRY_WIDTH-1:0] pop_data;

   // classify requests
   cdo_front #(
      .DAYS_WIDTH(DAYS_WIDTH),
      .YEAR_WIDTH(YEAR_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // hold classified requests
   cdo_queue #(
      .WIDTH(ENTRY_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // walk months and respond
   cdo_back #(
      .DAYS_WIDTH(DAYS_WIDTH),
      .YEAR_WIDTH(YEAR_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

`ifndef ASSERT_OFF
   // error responses carry an all-zero date
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |->
      ((rsp_ch.result_month == 4'd0) && (rsp_ch.result_day == 5'd0) &&
       (rsp_ch.result_year == '0)))
      else $error("error response with nonzero date");

   // good responses carry a real calendar date
   a_ok_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_OK)) |->
      ((rsp_ch.result_month >= MONTH_JAN) && (rsp_ch.result_month <= MONTH_DEC) &&
       (rsp_ch.result_day != 5'd0) && (rsp_ch.result_year != '0)))
      else $error("ok response with impossible date");

   // the back end never takes a new entry while it is still walking the last one
   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> !pop_ready)
      else $error("back end took two entries back to back");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for calendar_day_offset: date add/subtract requests
// checked against an in-bench calendar predictor. Uses cdo_pkg and both channel interfaces.
module tb_top;
   import cdo_pkg::*;

   localparam int DAYS_W     = 16;
   localparam int YEAR_W     = 14;
   localparam int YEAR_LIMIT = (1 << YEAR_W) - 1;
   localparam int DAYS_LIMIT = (1 << DAYS_W) - 1;
   localparam int DRAIN_CYCLES = 2300;

   typedef struct {
      logic              op;
      logic              date_present;
      logic [3:0]        start_month;
      logic [4:0]        start_day;
      logic [YEAR_W-1:0] start_year;
      logic [DAYS_W-1:0] day_count;
   } date_req_type;

   typedef struct {
      logic [3:0]        month;
      logic [4:0]        day;
      logic [YEAR_W-1:0] year;
      status_type        status;
   } date_rsp_type;

   logic clock = 1'b0;
   logic reset;

   cdo_req_if #(.DAYS_WIDTH(DAYS_W), .YEAR_WIDTH(YEAR_W)) req_bus ();
   cdo_rsp_if #(.YEAR_WIDTH(YEAR_W)) rsp_bus ();

   calendar_day_offset #(
      .DAYS_WIDTH(DAYS_W),
      .YEAR_WIDTH(YEAR_W)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   date_rsp_type expected_dates[$];
   bit        idle_enable = 1'b1;
   int        rsp_hold_cycles = 0;
   int        failures = 0;
   int        n_sent = 0;
   int        n_checked = 0;
   int        n_bad_date = 0;
   int        n_range = 0;

   // free-running clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // end the run if the block hangs
   initial begin
      #6000000;
      $display("Test completed with failures");
      $finish;
   end

   // Gregorian leap rule
   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input int y);
      int len;
      case (m)
         MONTH_FEB: len = leap_year(y) ? int'(LEN_FEB_LEAP) : int'(LEN_FEB_PLAIN);
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = int'(LEN_SHORT);
         default: len = int'(LEN_LONG);
      endcase
      return len;
   endfunction

   // walk the calendar one month at a time to find the offset date
   function automatic date_rsp_type predict_offset(input date_req_type r);
      int           m;
      int           d;
      int           y;
      status_type   st;
      date_rsp_type p;
      m  = int'(r.start_month);
      d  = int'(r.start_day);
      y  = int'(r.start_year);
      st = STATUS_OK;
      if (!r.date_present || m < 1 || m > 12 || y < 1 || d < 1 ||
          d > days_in_month(m, y)) begin
         st = STATUS_BAD_DATE;
      end else if (r.op == OP_ADD) begin
         d += int'(r.day_count);
         while (st == STATUS_OK && d > days_in_month(m, y)) begin
            d -= days_in_month(m, y);
            m++;
            if (m > 12) begin
               m = 1;
               y++;
               if (y > YEAR_LIMIT) st = STATUS_RANGE;
            end
         end
      end else begin
         d -= int'(r.day_count);
         while (st == STATUS_OK && d < 1) begin
            m--;
            if (m < 1) begin
               m = 12;
               y--;
               if (y < 1) st = STATUS_RANGE;
            end
            if (st == STATUS_OK) d += days_in_month(m, y);
         end
      end
      p.status = st;
      if (st == STATUS_OK) begin
         p.month = 4'(m);
         p.day   = 5'(d);
         p.year  = YEAR_W'(y);
      end else begin
         p.month = '0;
         p.day   = '0;
         p.year  = '0;
      end
      return p;
   endfunction

   task automatic check_field(input string name, input logic [31:0] expv,
                              input logic [31:0] actv);
      if (actv !== expv) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
         failures++;
      end
   endtask

   // offer one request, with an optional idle burst first; log the prediction on accept
   task automatic send_request(input date_req_type r);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = int'($urandom_range(1, 13));
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= r.op;
      req_bus.date_present <= r.date_present;
      req_bus.start_month  <= r.start_month;
      req_bus.start_day    <= r.start_day;
      req_bus.start_year   <= r.start_year;
      req_bus.day_count    <= r.day_count;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_dates.push_back(predict_offset(r));
      n_sent++;
   endtask

   task automatic send_date(input logic op, input logic present, input int m, input int d,
                            input int y, input int n);
      date_req_type r;
      r.op           = op;
      r.date_present = present;
      r.start_month  = 4'(m);
      r.start_day    = 5'(d);
      r.start_year   = YEAR_W'(y);
      r.day_count    = DAYS_W'(n);
      send_request(r);
   endtask

   // hold the request channel idle until every response is back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed dates with a spread of counts, some raw noise
   function automatic date_req_type random_request();
      date_req_type r;
      int        y;
      int        m;
      int        pick;
      r.op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) begin
         r.date_present = 1'($urandom_range(0, 1));
         r.start_month  = 4'($urandom_range(0, 15));
         r.start_day    = 5'($urandom_range(0, 31));
         r.start_year   = YEAR_W'($urandom_range(0, YEAR_LIMIT));
         r.day_count    = DAYS_W'($urandom_range(0, DAYS_LIMIT));
         return r;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 60)      y = int'($urandom_range(1, YEAR_LIMIT));
      else if (pick < 75) y = int'($urandom_range(1, 4));
      else if (pick < 90) y = int'($urandom_range(YEAR_LIMIT - 4, YEAR_LIMIT));
      else                y = 100 * int'($urandom_range(1, YEAR_LIMIT / 100));
      m = int'($urandom_range(1, 12));
      r.date_present = 1'b1;
      r.start_month  = 4'(m);
      r.start_year   = YEAR_W'(y);
      r.start_day    = 5'($urandom_range(1, days_in_month(m, y)));
      pick = int'($urandom_range(0, 99));
      if (pick < 60)      r.day_count = DAYS_W'($urandom_range(0, 400));
      else if (pick < 85) r.day_count = DAYS_W'($urandom_range(0, 4000));
      else                r.day_count = DAYS_W'($urandom_range(0, DAYS_LIMIT));
      return r;
   endfunction

   // response side: check each accepted response, drive ready with stall bursts
   initial begin
      int           stall_left;
      date_rsp_type want;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_dates.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0d/%0d/%0d st %0d",
                        $time, rsp_bus.result_month, rsp_bus.result_day,
                        rsp_bus.result_year, rsp_bus.status);
               failures++;
            end else begin
               want = expected_dates.pop_front();
               check_field("result_month", 32'(want.month), 32'(rsp_bus.result_month));
               check_field("result_day", 32'(want.day), 32'(rsp_bus.result_day));
               check_field("result_year", 32'(want.year), 32'(rsp_bus.result_year));
               check_field("status", 32'(want.status), 32'(rsp_bus.status));
               n_checked++;
               if (want.status == STATUS_BAD_DATE) n_bad_date++;
               if (want.status == STATUS_RANGE) n_range++;
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            stall_left = int'($urandom_range(1, 13)) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // boundaries, leap rules, invalid starts and range errors
   task automatic test_directed();
      send_date(OP_ADD, 1, 6, 15, 2021, 0);
      send_date(OP_SUB, 1, 6, 15, 2021, 0);
      send_date(OP_ADD, 1, 1, 31, 2021, 1);
      send_date(OP_ADD, 1, 12, 31, 1999, 1);
      send_date(OP_SUB, 1, 1, 1, 2000, 1);
      send_date(OP_ADD, 1, 2, 28, 2024, 1);
      send_date(OP_ADD, 1, 2, 28, 2023, 1);
      send_date(OP_ADD, 1, 2, 28, 1900, 1);
      send_date(OP_ADD, 1, 2, 28, 2000, 1);
      send_date(OP_SUB, 1, 3, 1, 2024, 1);
      send_date(OP_SUB, 1, 3, 1, 2100, 1);
      send_date(OP_ADD, 1, 1, 1, 1, DAYS_LIMIT);
      send_date(OP_SUB, 1, 12, 31, YEAR_LIMIT, DAYS_LIMIT);
      send_date(OP_ADD, 1, 12, 31, YEAR_LIMIT, 1);
      send_date(OP_SUB, 1, 1, 1, 1, 1);
      send_date(OP_SUB, 1, 1, 1, 100, DAYS_LIMIT);
      send_date(OP_ADD, 0, 5, 5, 2020, 10);
      send_date(OP_ADD, 1, 0, 5, 2020, 10);
      send_date(OP_SUB, 1, 13, 5, 2020, 10);
      send_date(OP_ADD, 1, 15, 31, YEAR_LIMIT, 10);
      send_date(OP_ADD, 1, 4, 0, 2020, 10);
      send_date(OP_SUB, 1, 4, 31, 2020, 10);
      send_date(OP_ADD, 1, 2, 29, 1900, 10);
      send_date(OP_ADD, 1, 2, 29, 2000, 10);
      send_date(OP_SUB, 1, 3, 3, 0, 10);
      wait_for_results();
   endtask

   task automatic test_random_dates(input int count);
      repeat (count) send_request(random_request());
      wait_for_results();
   endtask

   // stall the response side for a long stretch so the block fills up
   task automatic test_output_backpressure();
      date_req_type r;
      rsp_hold_cycles = 400;
      repeat (12) begin
         r = random_request();
         r.day_count = DAYS_W'(r.day_count % 64);
         send_request(r);
      end
      wait_for_results();
   endtask

   task automatic test_back_to_back(input int count);
      idle_enable = 1'b0;
      repeat (count) send_request(random_request());
      wait_for_results();
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_ADD;
      req_bus.date_present <= 1'b0;
      req_bus.start_month  <= '0;
      req_bus.start_day    <= '0;
      req_bus.start_year   <= '0;
      req_bus.day_count    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_dates(190);
      test_output_backpressure();
      test_back_to_back(45);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_dates.size() != 0) begin
         $display("%0t ns: %0d responses still outstanding", $time, expected_dates.size());
         failures++;
      end
      $display("Summary: %0d requests sent, %0d responses checked (%0d bad start, %0d range)",
               n_sent, n_checked, n_bad_date, n_range);
      $display("Covered add/subtract across month, year and leap edges, stalls and bursts");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
